@@ rtl/core/bdsp_pkg.sv @@
// bdsp_pkg: types, constants and codes shared by the deque search and product unit
// no dependencies
package bdsp_pkg;

   localparam int Depth = 16;
   localparam int IdxW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam int DataW = 32;
   localparam int StepW = $clog2(DataW + 1);

   typedef enum logic [2:0] {
      ACT_PUSH_BACK = 3'd0,
      ACT_POP_FRONT = 3'd1,
      ACT_POP_BACK  = 3'd2,
      ACT_SEARCH    = 3'd3,
      ACT_PRODUCT   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_NONE_DIV  = 3'd5,
      ST_ZERO_DIV  = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0]              action;
      logic signed [DataW-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [DataW-1:0] product_value;
      logic [CntW-1:0]         entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_ARITH,
      S_RESULT
   } state_type;

   // shared arithmetic unit operations
   typedef enum logic [1:0] {
      OP_REM = 2'd0,
      OP_MUL = 2'd1
   } op_type;

   typedef struct packed {
      logic             start;
      logic [1:0]       op;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [DataW-1:0] res;
   } alu_rsp_type;

endpackage

@@ rtl/core/bounded_deque_search_product_unit.sv @@
// bounded_deque_search_product_unit: top level, store, sequencer and result register
// depends on bdsp_pkg and bdsp_alu
//
// use: drive req_word and pulse start while busy is low; the word is taken at that edge.
// busy stays high until the result; rsp_valid then marks rsp_word for exactly one cycle
// and busy falls in the same cycle, so the next start may follow at once.
// push and pop go straight to the result state; search reads and compares each entry in
// turn and stops at the first match; product reads each entry and takes its remainder,
// and the bit-serial remainder and multiply unit dominates the time a product takes.
// a product entry not divisible skips the multiply.
// the receiver cannot stall: each result must be taken in its strobe cycle.
// reset clears the front index, count and sequencer; the store needs no clearing,
// since only written entries are read.
module bounded_deque_search_product_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bdsp_pkg::req_type req_word,
   output logic              rsp_valid,
   output bdsp_pkg::rsp_type rsp_word
);
   import bdsp_pkg::*;

   logic [DataW-1:0] store_mem [Depth];
   logic [DataW-1:0] rd_ff;

   state_type        state_ff, state_in;
   logic [IdxW-1:0]  front_ff, front_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  k_ff, k_in;
   logic [2:0]       act_ff, act_in;
   logic [DataW-1:0] val_ff, val_in;
   logic [DataW-1:0] prod_ff, prod_in;
   logic             any_ff, any_in;
   logic             mul_ff, mul_in;
   logic [2:0]       st_ff, st_in;
   logic             valid_ff, valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr, rd_addr;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   logic [DataW-1:0] dmag, emag;

   bdsp_alu u_alu (.clock(clock), .reset(reset), .alu_req(alu_req), .alu_rsp(alu_rsp));

   assign rd_addr = front_ff + k_ff[IdxW-1:0];
   assign wr_addr = front_ff + count_ff[IdxW-1:0];
   assign dmag = val_ff[DataW-1] ? -val_ff : val_ff;
   assign emag = rd_ff[DataW-1] ? -rd_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= val_ff;
      rd_ff <= store_mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      k_in = k_ff;
      act_in = act_ff;
      val_in = val_ff;
      prod_in = prod_ff;
      any_in = any_ff;
      mul_in = mul_ff;
      st_in = st_ff;
      valid_in = 1'b0;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      alu_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = req_word.action;
               val_in = req_word.value;
               k_in = '0;
               prod_in = DataW'(1);
               any_in = 1'b0;
               st_in = ST_DONE;
               state_in = S_EVAL;
               priority if (req_word.action == ACT_PUSH_BACK) begin
                  if (count_ff >= CntW'(Depth)) st_in = ST_FULL;
                  state_in = S_RESULT;
               end else if (req_word.action == ACT_POP_FRONT
                            || req_word.action == ACT_POP_BACK) begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  state_in = S_RESULT;
               end else if (req_word.action == ACT_SEARCH
                            || req_word.action == ACT_PRODUCT) begin
                  if (count_ff == '0) begin
                     st_in = ST_EMPTY;
                     state_in = S_RESULT;
                  end else if (req_word.action == ACT_PRODUCT && req_word.value == '0) begin
                     st_in = ST_ZERO_DIV;
                     state_in = S_RESULT;
                  end else begin
                     st_in = (req_word.action == ACT_SEARCH) ? ST_NOT_FOUND : ST_DONE;
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (act_ff == ACT_SEARCH) begin
               if (rd_ff == val_ff) begin
                  st_in = ST_FOUND;
                  state_in = S_RESULT;
               end else if (k_ff + CntW'(1) >= count_ff) begin
                  state_in = S_RESULT;
               end else begin
                  k_in = k_ff + CntW'(1);
                  state_in = S_READ;
               end
            end else begin
               alu_req.start = 1'b1;
               alu_req.op = OP_REM;
               alu_req.a = emag;
               alu_req.b = dmag;
               mul_in = 1'b0;
               state_in = S_ARITH;
            end
         end
         S_ARITH: begin
            if (alu_rsp.done) begin
               if (!mul_ff && alu_rsp.res == '0) begin
                  alu_req.start = 1'b1;
                  alu_req.op = OP_MUL;
                  alu_req.a = prod_ff;
                  alu_req.b = rd_ff;
                  any_in = 1'b1;
                  mul_in = 1'b1;
               end else begin
                  if (mul_ff) prod_in = alu_rsp.res;
                  if (k_ff + CntW'(1) >= count_ff) begin
                     state_in = S_RESULT;
                  end else begin
                     k_in = k_ff + CntW'(1);
                     state_in = S_READ;
                  end
               end
            end
         end
         S_RESULT: begin
            rsp_in.status = st_ff;
            rsp_in.product_value = '0;
            rsp_in.entry_count = count_ff;
            if (st_ff == ST_DONE) begin
               unique case (act_ff)
                  ACT_PUSH_BACK: begin
                     wr_en = 1'b1;
                     rsp_in.entry_count = count_ff + CntW'(1);
                  end
                  ACT_POP_FRONT: begin
                     front_in = front_ff + IdxW'(1);
                     rsp_in.entry_count = count_ff - CntW'(1);
                  end
                  ACT_POP_BACK: rsp_in.entry_count = count_ff - CntW'(1);
                  ACT_PRODUCT: begin
                     if (any_ff) rsp_in.product_value = prod_ff;
                     else rsp_in.status = ST_NONE_DIV;
                  end
                  default: ;
               endcase
            end
            count_in = rsp_in.entry_count;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      k_ff <= k_in;
      act_ff <= act_in;
      val_ff <= val_in;
      prod_ff <= prod_in;
      any_ff <= any_in;
      mul_ff <= mul_in;
      st_ff <= st_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_word = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth)) else $error("count beyond depth");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff) else $error("result strobe held");
   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(state_ff) == S_RESULT) else $error("result without work");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == S_RESULT)
      else $error("count changed outside result");

endmodule

@@ rtl/core/bdsp_alu.sv @@
// bdsp_alu: shared bit-serial unit for unsigned remainder and wrapping multiply
// depends on bdsp_pkg
module bdsp_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  bdsp_pkg::alu_req_type alu_req,
   output bdsp_pkg::alu_rsp_type alu_rsp
);
   import bdsp_pkg::*;

   logic             busy_ff, busy_in;
   logic             op_ff, op_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [DataW-1:0] a_ff, a_in;
   logic [DataW-1:0] b_ff, b_in;
   logic [DataW-1:0] acc_ff, acc_in;
   logic             done_ff, done_in;
   logic [DataW:0]   trial;
   logic [DataW-1:0] rem_shift;

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      step_in = step_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      done_in = 1'b0;
      rem_shift = {acc_ff[DataW-2:0], a_ff[DataW-1]};
      trial = {1'b0, rem_shift} - {1'b0, b_ff};
      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in = (alu_req.op == OP_MUL);
         a_in = alu_req.a;
         b_in = alu_req.b;
         acc_in = '0;
         step_in = '0;
      end else if (busy_ff) begin
         if (op_ff) begin
            // shift-add multiply, low word only
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end else begin
            // restoring division, remainder kept in acc
            // rem_shift may lose its top bit; b nonzero and rem < b keeps it exact
            if (acc_ff[DataW-1] || !trial[DataW]) acc_in = rem_shift - b_ff;
            else acc_in = rem_shift;
            a_in = a_ff << 1;
         end
         step_in = step_ff + StepW'(1);
         if (step_ff == StepW'(DataW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      step_ff <= step_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.res = acc_ff;

   a_done_one_shot: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |=> busy_ff) else $error("alu did not start");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("alu done without work");

endmodule
